@@ rtl/gf127_pkg.sv @@
// Package for the GF(2^127) arithmetic unit: widths, command codes,
// the inversion chain table and the narrow field functions it needs.
// No dependencies.
package gf127_pkg;

    localparam int F_W     = 127;
    localparam int DIG_W   = 8;
    localparam int SH_W    = 128;
    localparam int NUM_DIG = SH_W / DIG_W;
    localparam int DIG_CW  = $clog2(NUM_DIG);
    localparam int STEP_W  = 4;
    localparam int NSQ_W   = 6;
    localparam int IN_W    = 256;
    localparam int OUT_W   = 128;

    localparam logic [1:0] CMD_MUL = 2'd0;
    localparam logic [1:0] CMD_SQR = 2'd1;
    localparam logic [1:0] CMD_INV = 2'd2;

    // Multiplicand of one chain step.
    typedef enum logic [2:0] {
        MS_A, MS_START, MS_X6, MS_X24, MS_X30, MS_NONE
    } t_msel;

    // Where the result of a step is also kept.
    typedef enum logic [1:0] {
        SV_NONE, SV_X6, SV_X24, SV_X30
    } t_save;

    typedef struct packed {
        logic             src_x24;
        logic [NSQ_W-1:0] nsq;
        t_msel            msel;
        t_save            save;
    } t_inv_step;

    // Itoh-Tsujii chain 1,2,3,6,12,24,30,48,96,126 and a closing squaring.
    function automatic t_inv_step inv_step(input logic [STEP_W-1:0] idx);
        t_inv_step s;
        case (idx)
            4'd0:    s = '{1'b0, 6'd1,  MS_A,     SV_NONE};
            4'd1:    s = '{1'b0, 6'd1,  MS_A,     SV_NONE};
            4'd2:    s = '{1'b0, 6'd3,  MS_START, SV_X6};
            4'd3:    s = '{1'b0, 6'd6,  MS_START, SV_NONE};
            4'd4:    s = '{1'b0, 6'd12, MS_START, SV_X24};
            4'd5:    s = '{1'b0, 6'd6,  MS_X6,    SV_X30};
            4'd6:    s = '{1'b1, 6'd24, MS_X24,   SV_NONE};
            4'd7:    s = '{1'b0, 6'd48, MS_START, SV_NONE};
            4'd8:    s = '{1'b0, 6'd30, MS_X30,   SV_NONE};
            default: s = '{1'b0, 6'd1,  MS_NONE,  SV_NONE};
        endcase
        return s;
    endfunction

    // Reduce a polynomial of degree up to 252 modulo z^127 + z^63 + 1 in two folds.
    function automatic logic [F_W-1:0] gf_fold(input logic [252:0] w);
        logic [125:0] h;
        logic [61:0]  g;
        logic [F_W-1:0] r;
        h = w[252:127];
        g = h[125:64];
        r = w[126:0] ^ {1'b0, h} ^ {h[63:0], 63'b0};
        r = r ^ {65'b0, g} ^ {2'b0, g, 63'b0};
        return r;
    endfunction

    // Squaring is linear: spread the bits apart, then reduce.
    function automatic logic [F_W-1:0] gf_sqr(input logic [F_W-1:0] x);
        logic [252:0] w;
        w = '0;
        for (int i = 0; i < F_W; i++) begin
            w[2*i] = x[i];
        end
        return gf_fold(w);
    endfunction

    // One digit of a most-significant-digit-first multiply: acc*z^8 + m*d.
    function automatic logic [F_W-1:0] gf_mul_step(input logic [F_W-1:0] acc,
                                                   input logic [F_W-1:0] m,
                                                   input logic [DIG_W-1:0] d);
        logic [F_W+DIG_W-1:0] p;
        p = {acc, {DIG_W{1'b0}}};
        for (int j = 0; j < DIG_W; j++) begin
            p = p ^ (({{DIG_W{1'b0}}, m} << j) & {(F_W+DIG_W){d[j]}});
        end
        return gf_fold({118'b0, p});
    endfunction

endpackage

@@ rtl/gf2_127_field_arith_unit_top.sv @@
// Top level of the GF(2^127) arithmetic unit: sequencer, combinational squarer
// and an 8-bit digit-serial multiplier. Depends on gf127_pkg.
//
// Multiply works through the 16 digits of operand a, between the load and the
// hand-off; square does a single squaring, the unused command hands over zero,
// and invert does 132 squarings (131 in the chain and the closing one), 9
// multiplies, one setup state per chain step (10) and the load and hand-off.
// One item is worked at a time; the result register lets a finished result wait
// while a new item is taken, and a finished item waits while the result register
// still holds an untaken beat.
module gf2_127_field_arith_unit_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // cmd[1:0], a_lo[65:2], a_hi[128:66], b_lo[192:129], b_hi[255:193]
    input  logic [gf127_pkg::IN_W-1:0]     i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // r_lo[63:0], r_hi[126:64], zero in bit 127
    output logic [gf127_pkg::OUT_W-1:0]    o_m_tdata
);

    typedef enum logic [2:0] {ST_IDLE, ST_NEXT, ST_SQ, ST_MUL, ST_FIN} t_state;
    typedef enum logic [1:0] {MD_MUL, MD_SQR, MD_INV} t_mode;

    t_state                              r_state;
    t_mode                               r_mode;
    logic [gf127_pkg::F_W-1:0]           r_cur, r_m, r_acc, r_a, r_x6, r_x24, r_x30;
    logic [gf127_pkg::SH_W-1:0]          r_sh;
    logic [gf127_pkg::STEP_W-1:0]        r_step;
    logic [gf127_pkg::NSQ_W-1:0]         r_cnt;
    logic [gf127_pkg::DIG_CW-1:0]        r_dig;
    logic                                r_ovalid;
    logic [gf127_pkg::F_W-1:0]           r_out;

    gf127_pkg::t_inv_step                n_stp;
    logic [gf127_pkg::F_W-1:0]           n_sq, n_acc, n_src;
    logic                                n_in_acc;
    logic                                n_fin_go;

    // Narrow datapath pieces shared by all states.
    always_comb begin
        n_stp    = gf127_pkg::inv_step(r_step);
        n_sq     = gf127_pkg::gf_sqr(r_cur);
        n_acc    = gf127_pkg::gf_mul_step(r_acc, r_m,
                       r_sh[gf127_pkg::SH_W-1 -: gf127_pkg::DIG_W]);
        n_src    = n_stp.src_x24 ? r_x24 : r_cur;
        n_in_acc = i_s_tvalid && (r_state == ST_IDLE);
        n_fin_go = (r_state == ST_FIN) && (!r_ovalid || i_m_tready);
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_out};

    // Sequencer, datapath registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mode   <= MD_MUL;
            r_step   <= '0;
            r_cnt    <= '0;
            r_dig    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // The result beat is raised by a finished item and dropped once taken.
            if (n_fin_go) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_in_acc) begin
                        r_a    <= i_s_tdata[128:2];
                        r_step <= '0;
                        case (i_s_tdata[1:0])
                            gf127_pkg::CMD_MUL: begin
                                r_mode  <= MD_MUL;
                                r_cur   <= i_s_tdata[128:2];
                                r_sh    <= {1'b0, i_s_tdata[128:2]};
                                r_m     <= i_s_tdata[255:129];
                                r_acc   <= '0;
                                r_dig   <= '0;
                                r_state <= ST_MUL;
                            end
                            gf127_pkg::CMD_SQR: begin
                                r_mode  <= MD_SQR;
                                r_cur   <= i_s_tdata[128:2];
                                r_cnt   <= 6'd1;
                                r_state <= ST_SQ;
                            end
                            gf127_pkg::CMD_INV: begin
                                r_mode  <= MD_INV;
                                r_cur   <= i_s_tdata[128:2];
                                r_state <= ST_NEXT;
                            end
                            default: begin
                                r_cur   <= '0;
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_NEXT: begin
                    // Start one chain step: pick its source and multiplicand.
                    r_cur <= n_src;
                    r_cnt <= n_stp.nsq;
                    case (n_stp.msel)
                        gf127_pkg::MS_A:   r_m <= r_a;
                        gf127_pkg::MS_X6:  r_m <= r_x6;
                        gf127_pkg::MS_X24: r_m <= r_x24;
                        gf127_pkg::MS_X30: r_m <= r_x30;
                        default:           r_m <= n_src;
                    endcase
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_cur <= n_sq;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        if (r_mode == MD_SQR || n_stp.msel == gf127_pkg::MS_NONE) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_sh    <= {1'b0, n_sq};
                            r_acc   <= '0;
                            r_dig   <= '0;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_acc <= n_acc;
                    r_sh  <= r_sh << gf127_pkg::DIG_W;
                    r_dig <= r_dig + 1'b1;
                    if (r_dig == gf127_pkg::DIG_CW'(gf127_pkg::NUM_DIG - 1)) begin
                        r_cur <= n_acc;
                        if (r_mode == MD_INV) begin
                            case (n_stp.save)
                                gf127_pkg::SV_X6:  r_x6  <= n_acc;
                                gf127_pkg::SV_X24: r_x24 <= n_acc;
                                gf127_pkg::SV_X30: r_x30 <= n_acc;
                                default: ;
                            endcase
                            r_step  <= r_step + 1'b1;
                            r_state <= ST_NEXT;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    // Hand the result over once the result register is free.
                    if (n_fin_go) begin
                        r_out   <= r_cur;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/gf127_checker.sv @@
// Port-level checker for the GF(2^127) arithmetic unit, bound to its top level.
// Depends on gf127_pkg and gf2_127_field_arith_unit_top.
module gf127_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [gf127_pkg::OUT_W-1:0] o_m_tdata
);

    // A result beat that is not taken stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped before it was taken");

    // A waiting result beat keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("waiting result beat changed");

    // Once an operation is taken the unit is busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while an operation is in progress");

    // Results are always reduced to degree 126 or less.
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[gf127_pkg::OUT_W-1])
        else $error("result not fully reduced");

endmodule

bind gf2_127_field_arith_unit_top gf127_checker u_gf127_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
